### design/spherical_point_projector_macros.svh
// Assertion macros for the projector.
`ifndef SPHERICAL_POINT_PROJECTOR_MACROS_SVH
`define SPHERICAL_POINT_PROJECTOR_MACROS_SVH

`ifndef SYNTHESIS
`define SPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SPP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SPP_ASSERT(lbl, prop, msg)
`define SPP_ASSERT_RST(lbl, prop, msg)
`endif

`endif

### design/spp_pkg.sv
package spp_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned ANGLE_W       = 19;
  localparam int unsigned DIM_W         = 13;
  localparam int unsigned TAN_W         = 31;
  localparam int unsigned ENTRY_W       = 4;
  localparam int unsigned MAT_DEPTH     = 12;
  localparam int unsigned COORD_W       = 16;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 31;

  localparam int unsigned CORDIC_STEPS  = 28;
  localparam int unsigned STEP_W        = 5;
  localparam int unsigned Z_W           = 32;
  localparam int unsigned CS_W          = 33;
  localparam int unsigned MUL_W         = 34;
  localparam int unsigned PROD_W        = 2 * MUL_W;
  localparam int unsigned DEN_W         = 2 * TAN_W + 1;
  localparam int unsigned QUO_W         = 16;
  localparam int unsigned NUM_W_DEF     = DIM_W + 2 * TAN_W + 1;

  localparam logic signed [Z_W-1:0]  PI_Q28          = 32'sd843314857;
  localparam logic signed [Z_W-1:0]  HALF_PI_Q28     = 32'sd421657428;
  localparam logic signed [CS_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  localparam logic [STATUS_W-1:0] ST_PROJECTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LOADED     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_DEPTH = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SATURATED  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAN_HALF      = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic signed [Z_W-1:0] atan_q28(input logic [STEP_W-1:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      5'd0:    v = 32'sd210828714;
      5'd1:    v = 32'sd124459457;
      5'd2:    v = 32'sd65760959;
      5'd3:    v = 32'sd33381290;
      5'd4:    v = 32'sd16755422;
      5'd5:    v = 32'sd8385879;
      5'd6:    v = 32'sd4193963;
      5'd7:    v = 32'sd2097109;
      5'd8:    v = 32'sd1048571;
      5'd9:    v = 32'sd524287;
      5'd10:   v = 32'sd262144;
      5'd11:   v = 32'sd131072;
      5'd12:   v = 32'sd65536;
      5'd13:   v = 32'sd32768;
      5'd14:   v = 32'sd16384;
      5'd15:   v = 32'sd8192;
      5'd16:   v = 32'sd4096;
      5'd17:   v = 32'sd2048;
      5'd18:   v = 32'sd1024;
      5'd19:   v = 32'sd512;
      5'd20:   v = 32'sd256;
      5'd21:   v = 32'sd128;
      5'd22:   v = 32'sd64;
      5'd23:   v = 32'sd32;
      5'd24:   v = 32'sd16;
      5'd25:   v = 32'sd8;
      5'd26:   v = 32'sd4;
      5'd27:   v = 32'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### design/spp_cordic.sv
module spp_cordic (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic signed [spp_pkg::ANGLE_W-1:0]     angle_i,
  output logic signed [spp_pkg::CS_W-1:0]        sin_o,
  output logic signed [spp_pkg::CS_W-1:0]        cos_o,
  output spp_pkg::unit_stat_t                    stat_o
);

  localparam int unsigned ZSH = spp_pkg::Z_W - spp_pkg::ANGLE_W - 1;

  logic                               busy_q, done_q, flip_q;
  logic [spp_pkg::STEP_W-1:0]         step_q;
  logic signed [spp_pkg::CS_W-1:0]    x_q, y_q, dx, dy;
  logic signed [spp_pkg::Z_W-1:0]     z_q, z_raw, z_fold, at;
  logic                               flip_d;

  always_comb begin
    z_raw  = $signed({angle_i[spp_pkg::ANGLE_W-1], angle_i, {ZSH{1'b0}}});
    z_fold = z_raw;
    flip_d = 1'b0;
    if (z_raw > spp_pkg::HALF_PI_Q28) begin
      z_fold = z_raw - spp_pkg::PI_Q28;
      flip_d = 1'b1;
    end else if (z_raw < -spp_pkg::HALF_PI_Q28) begin
      z_fold = z_raw + spp_pkg::PI_Q28;
      flip_d = 1'b1;
    end
    dx = y_q >>> step_q;
    dy = x_q >>> step_q;
    at = spp_pkg::atan_q28(step_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == spp_pkg::STEP_W'(spp_pkg::CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= spp_pkg::CORDIC_GAIN_Q30;
      y_q    <= '0;
      z_q    <= z_fold;
      flip_q <= flip_d;
    end else if (busy_q) begin
      if (z_q >= 0) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
    end
  end

  assign sin_o       = flip_q ? -y_q : y_q;
  assign cos_o       = flip_q ? -x_q : x_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

### design/spp_mul.sv
module spp_mul (
  input  logic                                 clk_i,
  input  logic signed [spp_pkg::MUL_W-1:0]     a_i,
  input  logic signed [spp_pkg::MUL_W-1:0]     b_i,
  output logic signed [spp_pkg::PROD_W-1:0]    p_o
);

  logic signed [spp_pkg::PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= spp_pkg::PROD_W'(a_i) * spp_pkg::PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

### design/spp_div.sv
module spp_div #(
  parameter int unsigned NUM_W = spp_pkg::NUM_W_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [NUM_W-1:0]                num_i,
  input  logic [spp_pkg::DEN_W-1:0]       den_i,
  output logic [spp_pkg::QUO_W-1:0]       quo_o,
  output logic                            big_o,
  output spp_pkg::unit_stat_t             stat_o
);

  localparam int unsigned QW    = spp_pkg::QUO_W;
  localparam int unsigned DW    = spp_pkg::DEN_W;
  localparam int unsigned REM_W = DW + 1;
  localparam int unsigned CNT_W = $clog2(QW);
  localparam int unsigned CMP_W = (NUM_W > DW + QW) ? NUM_W : DW + QW;

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_CHK  = 2'd1;
  localparam logic [1:0] D_RUN  = 2'd2;

  logic [1:0]        state_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              done_q, big_q;
  logic [NUM_W-1:0]  num_q;
  logic [DW-1:0]     den_q;
  logic [REM_W-1:0]  rem_q, rem2, rem_d;
  logic [QW-1:0]     low_q, quo_q;
  logic              ge, over;

  always_comb begin
    over  = CMP_W'(num_q) >= CMP_W'({den_q, {QW{1'b0}}});
    rem2  = {rem_q[REM_W-2:0], low_q[QW-1]};
    ge    = rem2 >= REM_W'(den_q);
    rem_d = ge ? rem2 - REM_W'(den_q) : rem2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        D_IDLE: if (start_i) state_q <= D_CHK;
        D_CHK: begin
          cnt_q <= '0;
          if (over) begin
            done_q  <= 1'b1;
            state_q <= D_IDLE;
          end else begin
            state_q <= D_RUN;
          end
        end
        D_RUN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(QW - 1)) begin
            done_q  <= 1'b1;
            state_q <= D_IDLE;
          end
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      D_IDLE: begin
        if (start_i) begin
          num_q <= num_i;
          den_q <= den_i;
        end
      end
      D_CHK: begin
        big_q <= over;
        rem_q <= REM_W'(num_q[NUM_W-1:QW]);
        low_q <= num_q[QW-1:0];
        quo_q <= '0;
      end
      D_RUN: begin
        rem_q <= rem_d;
        low_q <= {low_q[QW-2:0], 1'b0};
        quo_q <= {quo_q[QW-2:0], ge};
      end
      default: ;
    endcase
  end

  assign quo_o       = quo_q;
  assign big_o       = big_q;
  assign stat_o.busy = (state_q != D_IDLE);
  assign stat_o.done = done_q;

endmodule

### design/spherical_point_projector.sv
// Spherical point projector.
// Input channel (in_valid_i/in_ready_o) carries one beat per item: a load of
// one view matrix entry (rows 0 to 2, index row*4+column) or a point given
// as time, radius, polar angle and azimuth. Each beat gives one result beat
// on the output channel (out_valid_o/out_ready_i): screen x, screen y and a
// status code (projected, loaded, zero depth, saturated).
// A load goes straight to the done state. A projection does two 28-step
// CORDIC runs, a 19-step sequence on the one shared multiplier, a depth
// normalisation of up to about 20 shifts, then per axis six multiplier
// steps and a 16-step restoring division.
// The block takes one item at a time; in_ready_o is high only while idle.
// A finished result sits in the output register while the next item is
// taken; if the receiver stalls, the next result waits there until free.
// Reset sets the screen to 640x480 and tan_half_angle to 1.0; the matrix
// holds nothing until written. Registers are written through cfg_we_i; the
// user must write them only while idle, which the block does not enforce.
`include "spherical_point_projector_macros.svh"

module spherical_point_projector #(
  parameter int unsigned FRAC_BITS = spp_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [spp_pkg::CFG_IDX_W-1:0]           cfg_idx_i,
  input  logic [spp_pkg::CFG_DATA_W-1:0]          cfg_wdata_i,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic                                    operation_i,
  input  logic [spp_pkg::ENTRY_W-1:0]             entry_index_i,
  input  logic signed [spp_pkg::WORD_W-1:0]       entry_value_i,
  input  logic signed [spp_pkg::WORD_W-1:0]       time_coord_i,
  input  logic signed [spp_pkg::WORD_W-1:0]       radius_i,
  input  logic signed [spp_pkg::ANGLE_W-1:0]      polar_angle_i,
  input  logic signed [spp_pkg::ANGLE_W-1:0]      azimuth_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [spp_pkg::COORD_W-1:0]      screen_x_o,
  output logic signed [spp_pkg::COORD_W-1:0]      screen_y_o,
  output logic [spp_pkg::STATUS_W-1:0]            status_o
);

  localparam int unsigned MW    = spp_pkg::MUL_W;
  localparam int unsigned PW    = spp_pkg::PROD_W;
  localparam int unsigned TW    = spp_pkg::TAN_W;
  localparam int unsigned CW    = spp_pkg::COORD_W;
  localparam int unsigned ACC_W = 66 - FRAC_BITS;
  localparam int unsigned MA_W  = spp_pkg::DIM_W + TW;
  localparam int unsigned P_W   = 2 * TW;
  localparam int unsigned T2_W  = MA_W + FRAC_BITS;
  localparam int unsigned T1_W  = spp_pkg::DIM_W + P_W;
  localparam int unsigned NUM_W = ((T2_W > T1_W) ? T2_W : T1_W) + 1;
  localparam int unsigned SH30  = 30;

  localparam logic [4:0] MSTEP_MAT  = 5'd6;
  localparam logic [4:0] MSTEP_LAST = 5'd18;
  localparam logic [2:0] ASTEP_DIV  = 3'd5;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CA   = 4'd1;
  localparam logic [3:0] S_CAW  = 4'd2;
  localparam logic [3:0] S_CB   = 4'd3;
  localparam logic [3:0] S_CBW  = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_ZCHK = 4'd6;
  localparam logic [3:0] S_NORM = 4'd7;
  localparam logic [3:0] S_AXM  = 4'd8;
  localparam logic [3:0] S_AXD  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0]                       state_q;
  logic [4:0]                       step_q;
  logic                             axis_q, out_valid_q;
  logic [spp_pkg::DIM_W-1:0]        width_q, height_q;
  logic [TW-1:0]                    tan_q;

  logic signed [spp_pkg::WORD_W-1:0]  mat_q [spp_pkg::MAT_DEPTH];
  logic signed [spp_pkg::WORD_W-1:0]  t_q, r_q;
  logic signed [spp_pkg::ANGLE_W-1:0] pol_q, azi_q;
  logic signed [spp_pkg::CS_W-1:0]    st_q, ct_q, sp_q, cp_q;
  logic signed [MW-1:0]               tmp1_q, tmp2_q, p1_q, p2_q, p3_q;
  logic signed [ACC_W-1:0]            acc_q [3];
  logic [ACC_W-1:0]                   m_q [3];
  logic [2:0]                         ng_q;
  logic [P_W-1:0]                     pq_q;
  logic [MA_W-1:0]                    t2p_q, t1lo_q;
  logic [NUM_W-1:0]                   t1_q;
  logic                               neg_q, sat_q;
  logic [CW-1:0]                      res_x_q, res_y_q, out_x_q, out_y_q;
  logic [spp_pkg::STATUS_W-1:0]       res_st_q, out_st_q;

  logic                               in_acc, cor_start, div_start;
  logic signed [spp_pkg::ANGLE_W-1:0] cor_angle;
  logic signed [spp_pkg::CS_W-1:0]    cor_sin, cor_cos;
  spp_pkg::unit_stat_t                cor_stat, div_stat;
  logic signed [MW-1:0]               mul_a, mul_b;
  logic signed [PW-1:0]               prod;
  logic [3:0]                         mat_idx;
  logic [1:0]                         acc_row;
  logic [4:0]                         mat_off, acc_off;
  logic signed [spp_pkg::WORD_W:0]    r_ext, r_abs;
  logic [TW-1:0]                      hq, ma;
  logic [spp_pkg::DIM_W-1:0]          dim;
  logic                               na, same, t1_ge, neg_d, big_any;
  logic [NUM_W-1:0]                   t2_ext, num;
  logic [spp_pkg::QUO_W-1:0]          quo;
  logic                               quo_big, coord_sat;
  logic [CW-1:0]                      coord;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign cor_start  = (state_q == S_CA) || (state_q == S_CB);
  assign cor_angle  = (state_q == S_CA) ? pol_q : azi_q;
  assign div_start  = (state_q == S_AXM) && (step_q == 5'(ASTEP_DIV));

  spp_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .angle_i (cor_angle),
    .sin_o   (cor_sin),
    .cos_o   (cor_cos),
    .stat_o  (cor_stat)
  );

  spp_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  spp_div #(.NUM_W(NUM_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   ({pq_q, 1'b0}),
    .quo_o   (quo),
    .big_o   (quo_big),
    .stat_o  (div_stat)
  );

  always_comb begin
    r_ext   = (spp_pkg::WORD_W + 1)'(r_q);
    r_abs   = r_ext[spp_pkg::WORD_W] ? -r_ext : r_ext;
    hq      = (tan_q == '0) ? TW'(1) : tan_q;
    ma      = axis_q ? m_q[1][TW-1:0] : m_q[0][TW-1:0];
    dim     = axis_q ? height_q : width_q;
    na      = axis_q ? ng_q[1] : ng_q[0];
    mat_off = step_q - MSTEP_MAT;
    acc_off = step_q - (MSTEP_MAT + 5'd1);
    mat_idx = mat_off[3:0];
    acc_row = acc_off[3:2];
    big_any = (|m_q[0][ACC_W-1:TW]) || (|m_q[1][ACC_W-1:TW]) || (|m_q[2][ACC_W-1:TW]);

    t2_ext = NUM_W'(t2p_q) << FRAC_BITS;
    same   = (na == ng_q[2]);
    t1_ge  = t1_q >= t2_ext;
    neg_d  = !same && !t1_ge;
    if (same)       num = t1_q + t2_ext;
    else if (t1_ge) num = t1_q - t2_ext;
    else            num = t2_ext - t1_q;

    coord_sat = 1'b0;
    if (!neg_q) begin
      if (quo_big || quo > 16'd32767) begin
        coord     = 16'h7FFF;
        coord_sat = 1'b1;
      end else begin
        coord = quo;
      end
    end else begin
      if (quo_big || quo > 16'd32768) begin
        coord     = 16'h8000;
        coord_sat = 1'b1;
      end else begin
        coord = -quo;
      end
    end

    mul_a = '0;
    mul_b = '0;
    if (state_q == S_MUL) begin
      case (step_q)
        5'd0: begin mul_a = MW'(r_abs);  mul_b = MW'(st_q); end
        5'd1: begin mul_a = MW'(r_q);    mul_b = MW'(st_q); end
        5'd2: begin mul_a = MW'(r_q);    mul_b = MW'(ct_q); end
        5'd3: begin mul_a = tmp1_q;      mul_b = MW'(cp_q); end
        5'd4: begin mul_a = tmp2_q;      mul_b = MW'(sp_q); end
        default: begin
          if (step_q >= MSTEP_MAT && step_q < MSTEP_LAST) begin
            mul_a = MW'(mat_q[mat_idx]);
            case (mat_idx[1:0])
              2'd0:    mul_b = MW'(t_q);
              2'd1:    mul_b = p1_q;
              2'd2:    mul_b = p2_q;
              default: mul_b = p3_q;
            endcase
          end
        end
      endcase
    end else if (state_q == S_AXM) begin
      case (step_q)
        5'd0: begin mul_a = $signed(MW'(m_q[2][TW-1:0])); mul_b = $signed(MW'(hq)); end
        5'd1: begin mul_a = $signed(MW'(ma));  mul_b = $signed(MW'(dim)); end
        5'd2: begin mul_a = $signed(MW'(dim)); mul_b = $signed(MW'(pq_q[TW-1:0])); end
        5'd3: begin mul_a = $signed(MW'(dim)); mul_b = $signed(MW'(pq_q[P_W-1:TW])); end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      axis_q      <= 1'b0;
      out_valid_q <= 1'b0;
      width_q     <= 13'd640;
      height_q    <= 13'd480;
      tan_q       <= 31'd65536;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          spp_pkg::REG_SCREEN_WIDTH:  width_q  <= cfg_wdata_i[spp_pkg::DIM_W-1:0];
          spp_pkg::REG_SCREEN_HEIGHT: height_q <= cfg_wdata_i[spp_pkg::DIM_W-1:0];
          spp_pkg::REG_TAN_HALF:      tan_q    <= cfg_wdata_i[TW-1:0];
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_acc) state_q <= (operation_i == spp_pkg::OP_LOAD) ? S_DONE : S_CA;
        end
        S_CA:  state_q <= S_CAW;
        S_CAW: if (cor_stat.done) state_q <= S_CB;
        S_CB:  state_q <= S_CBW;
        S_CBW: begin
          if (cor_stat.done) begin
            step_q  <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          step_q <= step_q + 5'd1;
          if (step_q == MSTEP_LAST) state_q <= S_ZCHK;
        end
        S_ZCHK: state_q <= (acc_q[2] == '0) ? S_DONE : S_NORM;
        S_NORM: begin
          if (!big_any) begin
            axis_q  <= 1'b0;
            step_q  <= '0;
            state_q <= S_AXM;
          end
        end
        S_AXM: begin
          step_q <= step_q + 5'd1;
          if (step_q == 5'(ASTEP_DIV)) state_q <= S_AXD;
        end
        S_AXD: begin
          if (div_stat.done) begin
            if (!axis_q) begin
              axis_q  <= 1'b1;
              step_q  <= '0;
              state_q <= S_AXM;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (operation_i == spp_pkg::OP_LOAD) begin
            if (entry_index_i < 4'(spp_pkg::MAT_DEPTH)) mat_q[entry_index_i] <= entry_value_i;
            res_x_q  <= '0;
            res_y_q  <= '0;
            res_st_q <= spp_pkg::ST_LOADED;
          end else begin
            t_q   <= time_coord_i;
            r_q   <= radius_i;
            pol_q <= polar_angle_i;
            azi_q <= azimuth_i;
            sat_q <= 1'b0;
          end
        end
      end
      S_CAW: begin
        if (cor_stat.done) begin
          st_q <= cor_sin;
          ct_q <= cor_cos;
        end
      end
      S_CBW: begin
        if (cor_stat.done) begin
          sp_q     <= cor_sin;
          cp_q     <= cor_cos;
          acc_q[0] <= '0;
          acc_q[1] <= '0;
          acc_q[2] <= '0;
        end
      end
      S_MUL: begin
        case (step_q)
          5'd1: tmp1_q <= $signed(prod[SH30 +: MW]);
          5'd2: tmp2_q <= $signed(prod[SH30 +: MW]);
          5'd3: p3_q   <= $signed(prod[SH30 +: MW]);
          5'd4: p1_q   <= $signed(prod[SH30 +: MW]);
          5'd5: p2_q   <= $signed(prod[SH30 +: MW]);
          default: begin
            if (step_q > MSTEP_MAT) acc_q[acc_row] <= acc_q[acc_row] + ACC_W'(prod >>> FRAC_BITS);
          end
        endcase
      end
      S_ZCHK: begin
        res_x_q  <= '0;
        res_y_q  <= '0;
        res_st_q <= spp_pkg::ST_ZERO_DEPTH;
        for (int i = 0; i < 3; i++) begin
          ng_q[i] <= acc_q[i][ACC_W-1];
          m_q[i]  <= acc_q[i][ACC_W-1] ? ACC_W'(-acc_q[i]) : ACC_W'(acc_q[i]);
        end
      end
      S_NORM: begin
        if (big_any) begin
          for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
        end else if (m_q[2] == '0) begin
          m_q[2] <= ACC_W'(1);
        end
      end
      S_AXM: begin
        case (step_q)
          5'd1: pq_q   <= prod[P_W-1:0];
          5'd2: t2p_q  <= prod[MA_W-1:0];
          5'd3: t1lo_q <= prod[MA_W-1:0];
          5'd4: t1_q   <= NUM_W'(t1lo_q) + (NUM_W'(prod[MA_W-1:0]) << TW);
          5'd5: neg_q  <= neg_d;
          default: ;
        endcase
      end
      S_AXD: begin
        if (div_stat.done) begin
          if (!axis_q) begin
            res_x_q <= coord;
            sat_q   <= coord_sat;
          end else begin
            res_y_q  <= coord;
            res_st_q <= (sat_q || coord_sat) ? spp_pkg::ST_SATURATED : spp_pkg::ST_PROJECTED;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_x_q  <= res_x_q;
          out_y_q  <= res_y_q;
          out_st_q <= res_st_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign screen_x_o  = $signed(out_x_q);
  assign screen_y_o  = $signed(out_y_q);
  assign status_o    = out_st_q;

  `SPP_ASSERT(a_busy_after_beat, in_valid_i && in_ready_o |=> !in_ready_o, "took a second beat")
  `SPP_ASSERT(a_load_zero, out_valid_o && status_o == spp_pkg::ST_LOADED |-> screen_x_o == 16'sd0 && screen_y_o == 16'sd0, "load result not zero")
  `SPP_ASSERT(a_depth_zero, out_valid_o && status_o == spp_pkg::ST_ZERO_DEPTH |-> screen_x_o == 16'sd0 && screen_y_o == 16'sd0, "zero depth result not zero")
  `SPP_ASSERT_RST(a_idle_reset, !rst_ni |=> state_q == S_IDLE || rst_ni, "not idle after reset")

endmodule
